// ===== hdl/blst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blst_pkg
// Shared types and constants of the band level statistics tracker.
// ----------------------------------------------------------------------------
package blst_pkg;

    localparam int NUM_BANDS   = 31;
    localparam int BAND_AW     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    localparam int BAND_W      = 5;
    localparam int LEVEL_W     = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 48;

    localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = 8'd128;
    localparam logic [LEVEL_W-1:0] MIN_RESET   = 8'hFF;

    localparam logic MODE_CLEAR  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef logic [BAND_AW-1:0] t_band_addr;

    typedef struct packed {
        logic [LEVEL_W-1:0] maxv;
        logic [LEVEL_W-1:0] minv;
        logic [LEVEL_W-1:0] avg;
    } t_band_stat;

    localparam t_band_stat STAT_RESET = '{maxv: 8'd0, minv: MIN_RESET, avg: 8'd0};

    typedef struct packed {
        logic               mode;
        logic               band_ok;
        logic               band_zero;
        logic [LEVEL_W-1:0] raw;
        logic [LEVEL_W-1:0] corr_in;
        t_band_stat         cur_stat;
        logic [LEVEL_W-1:0] cur_corr;
        logic [LEVEL_W-1:0] cur_peak;
    } t_upd_req;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_band_stat         stat;
        logic [LEVEL_W-1:0] corr;
        logic [LEVEL_W-1:0] peak;
    } t_upd_rsp;

endpackage
`default_nettype wire

// ===== hdl/blst_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blst_update
// Modify step of the read-modify-write: sample mode corrects a level and folds
// it into band stats and frame peak; clear mode resets them, loads correction.
// ----------------------------------------------------------------------------
module blst_update (
    input  wire blst_pkg::t_upd_req i_req,
    output blst_pkg::t_upd_rsp      o_rsp
);
    import blst_pkg::*;

    logic [LEVEL_W-1:0] raw_eff;
    logic [LEVEL_W-1:0] sum;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W:0]   avg_sum;

    always_comb begin
        raw_eff = i_req.band_zero ? '0 : i_req.raw;
        sum     = raw_eff + i_req.cur_corr;
        level   = (sum > LEVEL_LIMIT) ? '0 : sum;
        avg_sum = {1'b0, i_req.cur_stat.avg} + {1'b0, level};

        o_rsp.level = '0;
        o_rsp.stat  = STAT_RESET;
        o_rsp.corr  = i_req.cur_corr;
        o_rsp.peak  = i_req.cur_peak;
        if (i_req.band_ok) begin
            if (i_req.mode == MODE_CLEAR) begin
                o_rsp.corr = i_req.corr_in;
                o_rsp.peak = '0;
            end else begin
                o_rsp.level     = level;
                o_rsp.stat.maxv = (level > i_req.cur_stat.maxv) ? level : i_req.cur_stat.maxv;
                o_rsp.stat.minv = (level < i_req.cur_stat.minv) ? level : i_req.cur_stat.minv;
                o_rsp.stat.avg  = avg_sum[LEVEL_W:1];
                if (i_req.band_zero) begin
                    o_rsp.peak = '0;
                end else if (raw_eff > i_req.cur_peak) begin
                    o_rsp.peak = raw_eff;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/band_level_statistics_tracker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// band_level_statistics_tracker_unit
// Per-band maximum, minimum and halving average of corrected third-octave
// levels, per-band correction and frame peak of raw levels.
//
// channel  dir  tdata (low bit up)                                tuser
// s        in   band[4:0] raw_level[12:5] correction[20:13]        mode
// m        out  result_band[4:0] corrected_level[12:5]            -
//               band_maximum[20:13] band_minimum[28:21]
//               band_average[36:29] frame_peak[44:37]
//
// One word per cycle unless the output stalls; words pass the update stage and
// output registers. Statistics and correction memories are read on acceptance
// and written back when the update stage advances; a back-to-back word on the
// same band takes the written value from a forwarding register.
// Reset clears per-band valid flags at once, so no clearing pass is needed.
// An output stall holds the update stage and then the input.
// ----------------------------------------------------------------------------
module band_level_statistics_tracker_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // band, raw_level, correction
    input  wire  [blst_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // mode
    input  wire  [blst_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // result_band, corrected_level, band_maximum, band_minimum,
    // band_average, frame_peak
    output logic [blst_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import blst_pkg::*;

    t_band_stat         r_stat_mem [NUM_BANDS];
    logic [LEVEL_W-1:0] r_corr_mem [NUM_BANDS];
    logic [NUM_BANDS-1:0] r_vld;

    logic [BAND_W-1:0]  in_band;
    logic               in_ok;
    t_band_addr         in_addr;
    logic               accept;

    logic               r_s1_valid;
    logic               r_s1_mode;
    logic [BAND_W-1:0]  r_s1_band;
    logic [LEVEL_W-1:0] r_s1_raw;
    logic [LEVEL_W-1:0] r_s1_corr;
    t_band_stat         r_stat_q;
    logic [LEVEL_W-1:0] r_corr_q;

    logic               r_fwd_hit;
    t_band_stat         r_fwd_stat;
    logic [LEVEL_W-1:0] r_fwd_corr;

    logic [LEVEL_W-1:0] r_peak;

    logic               r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic               s1_ok;
    t_band_addr         s1_addr;
    logic               s1_adv;
    logic               s1_vld;
    t_upd_req           upd_req;
    t_upd_rsp           upd_rsp;

    assign in_band = i_s_tdata[BAND_W-1:0];
    assign in_ok   = ({1'b0, in_band} < (BAND_W+1)'(NUM_BANDS));
    assign in_addr = t_band_addr'(in_band);
    assign s1_ok   = ({1'b0, r_s1_band} < (BAND_W+1)'(NUM_BANDS));
    assign s1_addr = t_band_addr'(r_s1_band);

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        s1_vld = 1'b0;
        if (s1_ok) begin
            s1_vld = r_vld[s1_addr];
        end
        upd_req.mode      = r_s1_mode;
        upd_req.band_ok   = s1_ok;
        upd_req.band_zero = (r_s1_band == '0);
        upd_req.raw       = r_s1_raw;
        upd_req.corr_in   = r_s1_corr;
        upd_req.cur_peak  = r_peak;
        if (r_fwd_hit) begin
            upd_req.cur_stat = r_fwd_stat;
            upd_req.cur_corr = r_fwd_corr;
        end else if (s1_vld) begin
            upd_req.cur_stat = r_stat_q;
            upd_req.cur_corr = r_corr_q;
        end else begin
            upd_req.cur_stat = STAT_RESET;
            upd_req.cur_corr = '0;
        end
    end

    blst_update u_update (
        .i_req (upd_req),
        .o_rsp (upd_rsp)
    );

    // memory read on acceptance, write back when the update stage advances
    always_ff @(posedge i_clk) begin
        if (accept && in_ok) begin
            r_stat_q <= r_stat_mem[in_addr];
            r_corr_q <= r_corr_mem[in_addr];
        end
        if (s1_adv && s1_ok) begin
            r_stat_mem[s1_addr] <= upd_rsp.stat;
            r_corr_mem[s1_addr] <= upd_rsp.corr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv && s1_ok) begin
                r_vld[s1_addr] <= 1'b1;
            end
            if (s1_adv) begin
                r_peak <= upd_rsp.peak;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_adv && s1_ok && (r_s1_band == in_band);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
                r_fwd_hit  <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode <= i_s_tuser[0];
            r_s1_band <= in_band;
            r_s1_raw  <= i_s_tdata[BAND_W +: LEVEL_W];
            r_s1_corr <= i_s_tdata[BAND_W+LEVEL_W +: LEVEL_W];
        end
        if (s1_adv) begin
            r_fwd_stat <= upd_rsp.stat;
            r_fwd_corr <= upd_rsp.corr;
            r_out_data <= {3'b000, upd_rsp.peak, upd_rsp.stat.avg, upd_rsp.stat.minv,
                           upd_rsp.stat.maxv, upd_rsp.level, r_s1_band};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("forward flag set without an item in the update stage");

    a_adv_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("advanced item did not reach the output register");

    a_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[20:13] <= LEVEL_LIMIT))
        else $error("band maximum above level limit");

    a_min_max_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[28:21] != MIN_RESET))
            |-> (r_out_data[28:21] <= r_out_data[20:13]))
        else $error("band minimum above band maximum");

endmodule
`default_nettype wire
